// File: hdl/eqg_pkg.sv
`timescale 1ns / 1ps
package eqg_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 24;
  localparam int SQRT_STAGES     = 31;

  localparam int LON_W  = 26;
  localparam int LAT_W  = 24;
  localparam int CFG_W  = 26;
  localparam int CFG_IDX_W = 2;
  localparam int DEG_W  = 27;
  localparam int TURN_W = 32;
  localparam int FRAC_W = TURN_W - ANGLE_FRAC_BITS - 3;
  localparam int QUO_W  = TURN_W - FRAC_W;
  localparam int RED_W  = $clog2(360 << ANGLE_FRAC_BITS);
  localparam int ANG_W  = RED_W;
  localparam int PRD_W  = TURN_W + 6;

  localparam logic [DEG_W-1:0] FULL_CIRCLE = DEG_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [DEG_W-1:0] TWO_CIRCLES = DEG_W'(720 << ANGLE_FRAC_BITS);

  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = RECIP_SHIFT - 5;
  localparam logic [RECIP_W-1:0] RECIP45 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd44) / 64'd45);
  localparam logic [RED_W-1:0] DIV45 = RED_W'(45);
  localparam logic [FRAC_W-1:0] HALF_ADD = FRAC_W'(22);
  localparam logic [PRD_W-1:0] TURN_SCALE = PRD_W'(45);
  localparam logic [PRD_W-1:0] DEG_ROUND = PRD_W'(64'd1 << (FRAC_W - 1));

  localparam int ROT_W = 34;
  localparam int VEC_W = 36;
  localparam int SIN_W = 32;
  localparam int SQ_W  = 62;

  localparam logic signed [ROT_W-1:0] ROT_START    = ROT_W'(652032874);
  localparam logic signed [ROT_W-1:0] QUARTER_TURN = ROT_W'(64'd1 << 30);
  localparam logic signed [ROT_W-1:0] HALF_TURN_S  = ROT_W'(64'd1 << 31);
  localparam logic [TURN_W-1:0]       HALF_TURN    = 32'h8000_0000;
  localparam logic signed [SIN_W-1:0] Q30_ONE      = SIN_W'(64'd1 << 30);
  localparam logic [SQ_W-1:0]         Q60_ONE      = SQ_W'(64'd1 << 60);
  localparam logic signed [2*ROT_W-1:0] QMUL_ROUND = (2*ROT_W)'(64'd1 << 29);

  localparam logic [CFG_IDX_W-1:0] CFG_POLE_RA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_DEC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CEL_LON  = 2'd2;

  localparam logic signed [LON_W-1:0] POLE_RA_RST  = 26'sd12639239;
  localparam logic signed [LAT_W-1:0] POLE_DEC_RST = 24'sd1777877;
  localparam logic signed [LON_W-1:0] CEL_LON_RST  = 26'sd8056466;

  typedef logic [TURN_W-1:0] turn_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    turn_t                   z;
  } vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  typedef logic [FRAC_W-1:0] frac_tbl_t [64];

  function automatic frac_tbl_t build_frac();
    frac_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = (i < 45) ? FRAC_W'(((i << FRAC_W) + 22) / 45) : '0;
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac();

  function automatic turn_t atan_turn(input int i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      24: return 32'h00000029;
      25: return 32'h00000014;
      26: return 32'h0000000A;
      27: return 32'h00000005;
      28: return 32'h00000003;
      29: return 32'h00000001;
      30: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic rot_t rot_step(input rot_t a, input int i);
    rot_t n;
    logic signed [ROT_W-1:0] at;
    at = $signed(ROT_W'(atan_turn(i)));
    if (a.z >= 0) begin
      n.x = a.x - (a.y >>> i);
      n.y = a.y + (a.x >>> i);
      n.z = a.z - at;
    end else begin
      n.x = a.x + (a.y >>> i);
      n.y = a.y - (a.x >>> i);
      n.z = a.z + at;
    end
    return n;
  endfunction

  function automatic vec_t vec_step(input vec_t a, input int i);
    vec_t n;
    if (a.y >= 0) begin
      n.x = a.x + (a.y >>> i);
      n.y = a.y - (a.x >>> i);
      n.z = a.z + atan_turn(i);
    end else begin
      n.x = a.x - (a.y >>> i);
      n.y = a.y + (a.x >>> i);
      n.z = a.z - atan_turn(i);
    end
    return n;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t a, input int k);
    sqrt_t n;
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] rb;
    b  = SQ_W'(1) << (60 - 2 * k);
    rb = a.r + b;
    if (a.n >= rb) begin
      n.n = a.n - rb;
      n.r = (a.r >> 1) + b;
    end else begin
      n.n = a.n;
      n.r = a.r >> 1;
    end
    return n;
  endfunction

  function automatic logic signed [ROT_W-1:0] qmul(input logic signed [ROT_W-1:0] a,
                                                   input logic signed [ROT_W-1:0] b);
    logic signed [2*ROT_W-1:0] p;
    p = (2*ROT_W)'(a) * (2*ROT_W)'(b) + QMUL_ROUND;
    return ROT_W'(p >>> 30);
  endfunction

endpackage

// File: hdl/eqg_in_if.sv
`timescale 1ns / 1ps
interface eqg_in_if import eqg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [LON_W-1:0] lon_in;
  logic signed [LAT_W-1:0] lat_in;

  modport source (output valid, func, lon_in, lat_in, input ready);
  modport sink   (input valid, func, lon_in, lat_in, output ready);
endinterface

// File: hdl/eqg_out_if.sv
`timescale 1ns / 1ps
interface eqg_out_if import eqg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LON_W-1:0] lon_out;
  logic signed [LAT_W-1:0] lat_out;

  modport source (output valid, lon_out, lat_out, input ready);
  modport sink   (input valid, lon_out, lat_out, output ready);
endinterface

// File: hdl/equatorial_galactic_conversion.sv
// pipeline: the 24-stage cordic chains and the 31-stage square root lie between
//   an accepted word and its result word on the output
// throughput: one word per cycle; the whole pipeline holds while the output
//   register is full and not taken
// reset: synchronous active-low rst_n clears all valid bits and loads the
//   pole registers with their default angles
`timescale 1ns / 1ps
module equatorial_galactic_conversion import eqg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  eqg_in_if.sink               in_w,
  eqg_out_if.source            out_w,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CS  = CORDIC_STAGES;
  localparam int R0  = 5;
  localparam int M0  = R0 + CS + 1;
  localparam int Q0  = M0 + 6;
  localparam int V0  = Q0 + SQRT_STAGES;
  localparam int F0  = V0 + CS + 1;
  localparam int LAT = F0 + 4;

  typedef struct packed {
    logic             neg;
    logic [DEG_W-1:0] mag;
  } dmag_t;

  typedef struct packed {
    logic             neg;
    logic [RED_W-1:0] mag;
  } red_t;

  logic signed [LON_W-1:0] pole_ra_r;
  logic signed [LAT_W-1:0] pole_dec_r;
  logic signed [LON_W-1:0] cel_lon_r;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [F0:0]    bk_r;

  // conversion to turns
  logic signed [DEG_W-1:0] d0_r   [3];
  dmag_t                   dm1_r  [3];
  dmag_t                   dm1_nxt[3];
  red_t                    dm2_r  [3];
  red_t                    dm3_r  [3];
  logic [QUO_W-1:0]        quo3_r [3];
  logic [QUO_W-1:0]        quo3_nxt[3];
  turn_t                   turn4_r [3];
  turn_t                   turn4_nxt[3];

  // sine and cosine
  rot_t                    rot_r  [CS+1][3];
  rot_t                    rot0_nxt[3];
  logic                    fl_r   [CS+1][3];
  logic                    fl0_nxt[3];
  logic signed [ROT_W-1:0] sn_r [3];
  logic signed [ROT_W-1:0] cs_r [3];

  // spherical products
  logic signed [ROT_W-1:0] yv1_r, t1_r, t2_r, t3_r, t4_r, cd1_r;
  logic signed [ROT_W-1:0] yv2_r, t1b_r, t4b_r, t5_r, t6_r;
  logic signed [VEC_W-1:0] yv3_r, xv3_r;
  logic signed [SIN_W-1:0] s3_r, s3_nxt;
  logic signed [ROT_W:0]   ssum;
  logic signed [VEC_W-1:0] yv4_r, xv4_r;
  logic signed [SIN_W-1:0] s4_r;
  logic [SQ_W-1:0]         sq4_r;
  logic signed [2*SIN_W-1:0] sqp;

  // square root
  sqrt_t                   sqs_r [SQRT_STAGES+1];
  logic signed [VEC_W-1:0] yvq_r [SQRT_STAGES+1];
  logic signed [VEC_W-1:0] xvq_r [SQRT_STAGES+1];
  logic signed [SIN_W-1:0] sq_s_r[SQRT_STAGES+1];

  // arctangent, longitude in lane 0, latitude in lane 1
  vec_t                    vec_r [CS+1][2];
  vec_t                    vec0_nxt[2];
  logic                    zr_r  [CS+1][2];
  logic                    zr0_nxt[2];
  logic signed [VEC_W-1:0] vx_in[2];
  logic signed [VEC_W-1:0] vy_in[2];

  // back to degrees and output reduction
  logic [PRD_W-1:0]        pr_r [2];
  logic [PRD_W-1:0]        pr_nxt[2];
  logic                    ng_r [2];
  logic                    ng_nxt[2];
  logic signed [ANG_W-1:0] ang[2];
  logic [PRD_W-1:0]        rnd[2];
  logic signed [DEG_W-1:0] lsum_r, lsum_nxt;
  logic [LAT_W-1:0]        lat1_r, lat2_r;
  logic                    fneg_r;
  logic [DEG_W-1:0]        fmag_r, fmag_nxt, fabs;
  logic [DEG_W-1:0]        fred;
  logic signed [LON_W-1:0] lon_out_r, lon_out_nxt;
  logic signed [LAT_W-1:0] lat_out_r;

  assign en         = !vld_r[LAT-1] || out_w.ready;
  assign in_w.ready = en;

  assign out_w.valid   = vld_r[LAT-1];
  assign out_w.lon_out = lon_out_r;
  assign out_w.lat_out = lat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_ra_r  <= POLE_RA_RST;
      pole_dec_r <= POLE_DEC_RST;
      cel_lon_r  <= CEL_LON_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_POLE_RA:  pole_ra_r  <= cfg_data[LON_W-1:0];
        CFG_POLE_DEC: pole_dec_r <= cfg_data[LAT_W-1:0];
        CFG_CEL_LON:  cel_lon_r  <= cfg_data[LON_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_w.valid};
    end
  end

  // degrees to turns: reduce into one circle, then split by 45 and look up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm1_nxt[i].neg = d0_r[i][DEG_W-1];
      dm1_nxt[i].mag = dm1_nxt[i].neg ? DEG_W'(-d0_r[i]) : DEG_W'(d0_r[i]);
      if (dm1_nxt[i].mag >= TWO_CIRCLES) begin
        dm1_nxt[i].mag = dm1_nxt[i].mag - TWO_CIRCLES;
      end
    end
  end

  always_comb begin
    logic [RED_W+RECIP_W-1:0] prod;
    logic [RED_W-1:0]         rem;
    turn_t                    q;
    for (int i = 0; i < 3; i++) begin
      prod        = (RED_W+RECIP_W)'(dm2_r[i].mag) * (RED_W+RECIP_W)'(RECIP45);
      quo3_nxt[i] = prod[RECIP_SHIFT +: QUO_W];
      rem         = dm3_r[i].mag - RED_W'(quo3_r[i]) * DIV45;
      q           = {quo3_r[i], FRAC_TBL[rem[5:0]]};
      turn4_nxt[i] = dm3_r[i].neg ? -q : q;
    end
  end

  // fold into the right half plane before rotation
  always_comb begin
    logic signed [ROT_W-1:0] zs;
    for (int i = 0; i < 3; i++) begin
      zs = ROT_W'($signed(turn4_r[i]));
      fl0_nxt[i] = 1'b0;
      if (zs > QUARTER_TURN) begin
        zs = zs - HALF_TURN_S;
        fl0_nxt[i] = 1'b1;
      end else if (zs < -QUARTER_TURN) begin
        zs = zs + HALF_TURN_S;
        fl0_nxt[i] = 1'b1;
      end
      rot0_nxt[i].x = ROT_START;
      rot0_nxt[i].y = '0;
      rot0_nxt[i].z = zs;
    end
  end

  always_comb begin
    ssum = (ROT_W+1)'(t4b_r) + (ROT_W+1)'(t6_r);
    if (ssum > (ROT_W+1)'(Q30_ONE)) begin
      s3_nxt = Q30_ONE;
    end else if (ssum < -(ROT_W+1)'(Q30_ONE)) begin
      s3_nxt = -Q30_ONE;
    end else begin
      s3_nxt = SIN_W'(ssum);
    end
    sqp = (2*SIN_W)'(s3_r) * (2*SIN_W)'(s3_r);
  end

  always_comb begin
    vy_in[0] = yvq_r[SQRT_STAGES];
    vx_in[0] = xvq_r[SQRT_STAGES];
    vy_in[1] = VEC_W'(sq_s_r[SQRT_STAGES]);
    vx_in[1] = $signed(VEC_W'(sqs_r[SQRT_STAGES].r));
    for (int j = 0; j < 2; j++) begin
      zr0_nxt[j] = (vx_in[j] == '0) && (vy_in[j] == '0);
      if (vx_in[j] < 0) begin
        vec0_nxt[j].x = -vx_in[j];
        vec0_nxt[j].y = -vy_in[j];
        vec0_nxt[j].z = HALF_TURN;
      end else begin
        vec0_nxt[j].x = vx_in[j];
        vec0_nxt[j].y = vy_in[j];
        vec0_nxt[j].z = '0;
      end
    end
  end

  // turns to degrees, rounded half away from zero
  always_comb begin
    turn_t t;
    turn_t m;
    for (int j = 0; j < 2; j++) begin
      t         = zr_r[CS][j] ? '0 : vec_r[CS][j].z;
      ng_nxt[j] = t > HALF_TURN;
      m         = ng_nxt[j] ? -t : t;
      pr_nxt[j] = PRD_W'(m) * TURN_SCALE;
      rnd[j]    = (pr_r[j] + DEG_ROUND) >> FRAC_W;
      ang[j]    = ng_r[j] ? -$signed(rnd[j][ANG_W-1:0]) : $signed(rnd[j][ANG_W-1:0]);
    end
    if (bk_r[F0]) begin
      lsum_nxt = DEG_W'(pole_ra_r) + DEG_W'(ang[0]);
    end else begin
      lsum_nxt = DEG_W'(cel_lon_r) - DEG_W'(ang[0]);
    end
  end

  // remainder of 360 degrees that keeps the sign of the sum
  always_comb begin
    fabs     = lsum_r[DEG_W-1] ? DEG_W'(-lsum_r) : DEG_W'(lsum_r);
    fmag_nxt = (fabs >= TWO_CIRCLES) ? fabs - TWO_CIRCLES : fabs;
    fred     = (fmag_r >= FULL_CIRCLE) ? fmag_r - FULL_CIRCLE : fmag_r;
    lon_out_nxt = fneg_r ? -$signed(fred[LON_W-1:0]) : $signed(fred[LON_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bk_r <= {bk_r[F0-1:0], in_w.func};

      d0_r[0] <= DEG_W'(in_w.lon_in) - (in_w.func ? DEG_W'(cel_lon_r) : DEG_W'(pole_ra_r));
      d0_r[1] <= DEG_W'(in_w.lat_in);
      d0_r[2] <= DEG_W'(pole_dec_r);

      for (int i = 0; i < 3; i++) begin
        dm1_r[i]     <= dm1_nxt[i];
        dm2_r[i].neg <= dm1_r[i].neg;
        dm2_r[i].mag <= (dm1_r[i].mag >= FULL_CIRCLE) ? RED_W'(dm1_r[i].mag - FULL_CIRCLE)
                                                      : RED_W'(dm1_r[i].mag);
        dm3_r[i]     <= dm2_r[i];
        quo3_r[i]    <= quo3_nxt[i];
        turn4_r[i]   <= turn4_nxt[i];
        rot_r[0][i]  <= rot0_nxt[i];
        fl_r[0][i]   <= fl0_nxt[i];
        for (int k = 1; k <= CS; k++) begin
          rot_r[k][i] <= rot_step(rot_r[k-1][i], k - 1);
          fl_r[k][i]  <= fl_r[k-1][i];
        end
        sn_r[i] <= fl_r[CS][i] ? -rot_r[CS][i].y : rot_r[CS][i].y;
        cs_r[i] <= fl_r[CS][i] ? -rot_r[CS][i].x : rot_r[CS][i].x;
      end

      // lane 0: longitude difference, lane 1: latitude, lane 2: pole declination
      yv1_r <= qmul(cs_r[1], sn_r[0]);
      t1_r  <= qmul(sn_r[1], cs_r[2]);
      t2_r  <= qmul(cs_r[1], sn_r[2]);
      t3_r  <= qmul(cs_r[1], cs_r[2]);
      t4_r  <= qmul(sn_r[1], sn_r[2]);
      cd1_r <= cs_r[0];

      yv2_r <= yv1_r;
      t1b_r <= t1_r;
      t4b_r <= t4_r;
      t5_r  <= qmul(t2_r, cd1_r);
      t6_r  <= qmul(t3_r, cd1_r);

      yv3_r <= bk_r[M0+2] ? -VEC_W'(yv2_r) : VEC_W'(yv2_r);
      xv3_r <= VEC_W'(t1b_r) - VEC_W'(t5_r);
      s3_r  <= s3_nxt;

      yv4_r <= yv3_r;
      xv4_r <= xv3_r;
      s4_r  <= s3_r;
      sq4_r <= sqp[SQ_W-1:0];

      sqs_r[0].n <= Q60_ONE - sq4_r;
      sqs_r[0].r <= '0;
      yvq_r[0]   <= yv4_r;
      xvq_r[0]   <= xv4_r;
      sq_s_r[0]  <= s4_r;
      for (int k = 1; k <= SQRT_STAGES; k++) begin
        sqs_r[k]  <= sqrt_step(sqs_r[k-1], k - 1);
        yvq_r[k]  <= yvq_r[k-1];
        xvq_r[k]  <= xvq_r[k-1];
        sq_s_r[k] <= sq_s_r[k-1];
      end

      for (int j = 0; j < 2; j++) begin
        vec_r[0][j] <= vec0_nxt[j];
        zr_r[0][j]  <= zr0_nxt[j];
        for (int k = 1; k <= CS; k++) begin
          vec_r[k][j] <= vec_step(vec_r[k-1][j], k - 1);
          zr_r[k][j]  <= zr_r[k-1][j];
        end
        pr_r[j] <= pr_nxt[j];
        ng_r[j] <= ng_nxt[j];
      end

      lsum_r    <= lsum_nxt;
      lat1_r    <= ang[1][LAT_W-1:0];
      fneg_r    <= lsum_r[DEG_W-1];
      fmag_r    <= fmag_nxt;
      lat2_r    <= lat1_r;
      lon_out_r <= lon_out_nxt;
      lat_out_r <= lat2_r;
    end
  end

endmodule

// File: bench/equatorial_galactic_conversion_tb.sv
`timescale 1ns / 1ps
module equatorial_galactic_conversion_tb;
  import eqg_pkg::*;

  typedef struct {
    bit [LON_W-1:0] lon;
    bit [LAT_W-1:0] lat;
  } coord_pair_t;

  localparam bit [31:0] ARC_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };
  localparam longint DEG_CIRCLE = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint UNIT_Q30   = longint'(1) << 30;
  localparam int     LON_MAX    = 23592960;
  localparam int     LAT_MAX    = 5898240;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  eqg_in_if  in_w ();
  eqg_out_if out_w ();

  equatorial_galactic_conversion dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_w     (in_w),
    .out_w    (out_w),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  bit [25:0] pole_ra_reg;
  bit [23:0] pole_dec_reg;
  bit [25:0] cel_lon_reg;
  coord_pair_t pending_pairs [$];
  int err_count;
  bit out_free_run;
  bit in_free_run;
  int ready_hold;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int pick_gap(bit free_run);
    if (free_run) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint scale_q30(longint a, longint b);
    return (a * b + (UNIT_Q30 >>> 1)) >>> 30;
  endfunction

  function automatic bit [31:0] degrees_to_turn(longint d);
    longint unsigned m;
    longint unsigned q;
    m = (d < 0) ? longint'(-d) : longint'(d);
    q = ((m << 32) + DEG_CIRCLE / 2) / DEG_CIRCLE;
    if (d < 0) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic longint turn_to_degrees(bit [31:0] t);
    bit neg;
    longint unsigned m;
    longint unsigned r;
    neg = t > 32'h8000_0000;
    m = neg ? (64'h1_0000_0000 - t) : {32'd0, t};
    r = (m * DEG_CIRCLE + (64'd1 << 31)) >> 32;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void rotate_turn(input bit [31:0] t, output longint s, output longint c);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit flip;
    z = t[31] ? longint'({32'd0, t}) - 64'sh1_0000_0000 : longint'({32'd0, t});
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > UNIT_Q30) begin
      z = z - 2 * UNIT_Q30;
      flip = 1'b1;
    end else if (z < -UNIT_Q30) begin
      z = z + 2 * UNIT_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'({32'd0, ARC_TURN[i]});
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'({32'd0, ARC_TURN[i]});
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic bit [31:0] vector_turn(longint y, longint x);
    bit [31:0] z;
    longint nx;
    z = 32'd0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARC_TURN[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARC_TURN[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic bit [31:0] arcsine_turn(longint s);
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    if (s > UNIT_Q30) s = UNIT_Q30;
    if (s < -UNIT_Q30) s = -UNIT_Q30;
    n = longint'(UNIT_Q30 * UNIT_Q30) - longint'(s * s);
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return vector_turn(s, longint'(r));
  endfunction

  function automatic coord_pair_t convert_pair(bit back, bit [LON_W-1:0] lon_f,
                                               bit [LAT_W-1:0] lat_f);
    coord_pair_t res;
    longint lon, lat, ra0, dec0, l0;
    longint sd, cd, sa, ca, sp, cp, yv, xv, ang, lon_r, lat_r;
    lon = longint'($signed(lon_f));
    lat = longint'($signed(lat_f));
    ra0 = longint'($signed(pole_ra_reg));
    dec0 = longint'($signed(pole_dec_reg));
    l0 = longint'($signed(cel_lon_reg));
    rotate_turn(degrees_to_turn(lon - (back ? l0 : ra0)), sd, cd);
    rotate_turn(degrees_to_turn(lat), sa, ca);
    rotate_turn(degrees_to_turn(dec0), sp, cp);
    yv = scale_q30(ca, sd);
    if (back) yv = -yv;
    xv = scale_q30(sa, cp) - scale_q30(scale_q30(ca, sp), cd);
    ang = turn_to_degrees(vector_turn(yv, xv));
    lon_r = back ? ra0 + ang : l0 - ang;
    lon_r = lon_r % DEG_CIRCLE;
    lat_r = turn_to_degrees(arcsine_turn(scale_q30(sa, sp) + scale_q30(scale_q30(ca, cp), cd)));
    res.lon = lon_r[LON_W-1:0];
    res.lat = lat_r[LAT_W-1:0];
    return res;
  endfunction

  // output side stall pattern
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_free_run) begin
      out_w.ready <= 1'b1;
    end else begin
      out_w.ready <= ($urandom_range(0, 3) != 0);
      ready_hold <= pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    coord_pair_t want;
    if (rst_n && out_w.valid && out_w.ready) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected word lon_out=%0d lat_out=%0d", $time,
                 out_w.lon_out, out_w.lat_out);
        err_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_w.lon_out !== want.lon) begin
          $display("%0t: lon_out expected %0d actual %0d", $time,
                   $signed(want.lon), out_w.lon_out);
          err_count++;
        end
        if (out_w.lat_out !== want.lat) begin
          $display("%0t: lat_out expected %0d actual %0d", $time,
                   $signed(want.lat), out_w.lat_out);
          err_count++;
        end
      end
    end
  end

  task automatic send_word(bit f, bit [LON_W-1:0] lon, bit [LAT_W-1:0] lat);
    int gap;
    in_w.func <= f;
    in_w.lon_in <= lon;
    in_w.lat_in <= lat;
    in_w.valid <= 1'b1;
    do @(posedge clk); while (!in_w.ready);
    pending_pairs.push_back(convert_pair(f, lon, lat));
    gap = pick_gap(in_free_run);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_w.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLE_RA:  pole_ra_reg = value[25:0];
      CFG_POLE_DEC: pole_dec_reg = value[23:0];
      CFG_CEL_LON:  cel_lon_reg = value[25:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_poles(int ra, int dec, int lon);
    write_reg(CFG_POLE_RA, CFG_W'(ra));
    write_reg(CFG_POLE_DEC, CFG_W'(dec));
    write_reg(CFG_CEL_LON, CFG_W'(lon));
  endtask

  function automatic int ranged(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic test_directed();
    int ra0, dec0;
    ra0 = $signed(pole_ra_reg);
    dec0 = $signed(pole_dec_reg);
    for (int f = 0; f < 2; f++) begin
      send_word(f, LON_W'(LON_MAX), LAT_W'(LAT_MAX));
      send_word(f, LON_W'(-LON_MAX), LAT_W'(-LAT_MAX));
      send_word(f, '0, '0);
      send_word(f, LON_W'(LON_MAX), LAT_W'(-LAT_MAX));
      send_word(f, {1'b0, {(LON_W-1){1'b1}}}, {1'b0, {(LAT_W-1){1'b1}}});
      send_word(f, {1'b1, {(LON_W-1){1'b0}}}, {1'b1, {(LAT_W-1){1'b0}}});
    end
    // position at the pole, and the half turn with d equal zero
    send_word(1'b0, LON_W'(ra0), LAT_W'(dec0));
    send_word(1'b0, LON_W'(ra0), LAT_W'(-LAT_MAX / 2));
    send_word(1'b1, cel_lon_reg, LAT_W'(-LAT_MAX / 2));
    send_word(1'b1, cel_lon_reg, LAT_W'(dec0));
    send_word(1'b0, LON_W'(ra0 + 11796480), LAT_W'(-dec0));
    drain_results();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 25 == 0) begin
        in_free_run = ($urandom_range(0, 3) == 0);
        out_free_run = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 3) == 0)
        send_word($urandom_range(0, 1), LON_W'($urandom), LAT_W'($urandom));
      else
        send_word($urandom_range(0, 1), LON_W'(ranged(LON_MAX)), LAT_W'(ranged(LAT_MAX)));
    end
    in_free_run = 1'b0;
    out_free_run = 1'b0;
    drain_results();
  endtask

  task automatic test_pressure();
    for (int k = 0; k < 30; k++) begin
      send_word($urandom_range(0, 1), LON_W'(ranged(LON_MAX)), LAT_W'(ranged(LAT_MAX)));
      if (k % 10 == 9) begin
        in_w.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
      end
    end
    drain_results();
  endtask

  initial begin
    err_count = 0;
    out_free_run = 1'b0;
    in_free_run = 1'b0;
    ready_hold = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_w.valid = 1'b0;
    in_w.func = 1'b0;
    in_w.lon_in = '0;
    in_w.lat_in = '0;
    out_w.ready = 1'b0;
    pole_ra_reg = 26'd12639239;
    pole_dec_reg = 24'd1777877;
    cel_lon_reg = 26'd8056466;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(40);
    test_pressure();
    write_poles(ranged(LON_MAX), ranged(LAT_MAX), ranged(LON_MAX));
    test_directed();
    test_random(60);
    write_poles(-LON_MAX, -LAT_MAX, -LON_MAX);
    test_random(60);
    write_poles(LON_MAX, LAT_MAX, LON_MAX);
    test_directed();
    test_random(60);
    write_poles(0, 0, 0);
    test_random(50);
    write_poles(int'($urandom), int'($urandom), int'($urandom));
    test_random(60);
    write_poles(12639239, 1777877, 8056466);
    test_random(60);
    if (err_count == 0) begin
      $display("equatorial_galactic_conversion_tb passed");
    end else begin
      $display("equatorial_galactic_conversion_tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("equatorial_galactic_conversion_tb failed");
    $finish;
  end

endmodule
